// ===== design/awvn_pkg.sv =====
// awvn_pkg: shared constants, codes and control structs for the vertex normal block
// no dependencies; used by the interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package awvn_pkg;

    // store geometry
    localparam int VTX_DEPTH = 1024;
    localparam int VTX_AW    = 10;
    localparam int FACE_DEPTH = 2048;
    localparam int FACE_AW   = 11;

    // field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 11;
    localparam int COORD_W  = 16;
    localparam int IDX_W    = 10;
    localparam int NRM_W    = 16;
    localparam int CNT_W    = 12;
    localparam int STAT_W   = 2;
    localparam int VCNT_W   = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;

    // datapath widths
    localparam int DIFF_W   = COORD_W + 1;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SUM_W    = 48;
    localparam int MAG_W    = 30;
    localparam int SSQ_W    = 62;
    localparam int LEN_W    = 31;
    localparam int DIVS_W   = LEN_W + 1;
    localparam int QSH      = 15;
    localparam int DIVD_W   = MAG_W + QSH + 1;
    localparam int Q_W      = 16;
    localparam int STEP_W   = 3;
    localparam int ITER_W   = 6;
    localparam int COMP_W   = 2;

    // iteration counts and the faces-used limit
    localparam int ROOT_STEPS = SSQ_W / 2;
    localparam int DIV_STEPS  = DIVD_W;
    localparam int CROSS_STEPS = 6;
    localparam int SQ_STEPS   = 3;
    localparam int USED_MAX   = (1 << CNT_W) - 1;

    // opcodes
    localparam logic [OP_W-1:0] OP_LOAD_VTX  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_FACE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACE_COUNT   = 1'b1;

    // triangle corner select for the vertex store read
    typedef enum logic [1:0] {
        CRN_A = 2'd0,
        CRN_B = 2'd1,
        CRN_C = 2'd2
    } corner_t;

    // commands from controller to datapath
    typedef struct packed {
        logic                load_vtx;
        logic                load_face;
        logic                start;
        logic                face_next;
        logic                hit_count;
        corner_t             corner;
        logic                latch_a;
        logic                latch_u;
        logic                latch_w;
        logic                mul_en;
        logic                mul_sq;
        logic                sum_check;
        logic                norm_shift;
        logic                root_init;
        logic                root_step;
        logic                div_init;
        logic                div_step;
        logic                div_store;
        logic                out_load;
        logic [STAT_W-1:0]   status;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_of_range;
        logic walk_done;
        logic face_hit;
        logic sum_zero;
        logic norm_done;
        logic step_last;
        logic root_last;
        logic div_last;
        logic comp_last;
        logic out_full;
    } stat_t;

endpackage

`default_nettype wire

// ===== design/awvn_ifs.sv =====
// awvn_in_if / awvn_out_if: valid-ready channels for query items and result items
// depends on awvn_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface awvn_in_if;
    import awvn_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           opcode;
    logic [SLOT_W-1:0]         slot;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [IDX_W-1:0]          corner_a;
    logic [IDX_W-1:0]          corner_b;
    logic [IDX_W-1:0]          corner_c;

    modport source (
        output valid, opcode, slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
        output ready
    );
endinterface

interface awvn_out_if;
    import awvn_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [CNT_W-1:0]        faces_used;
    logic [STAT_W-1:0]       status;

    modport source (
        output valid, normal_x, normal_y, normal_z, faces_used, status,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, faces_used, status,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/area_weighted_vertex_normals.sv =====
// Area-weighted vertex normals: loads write the stores and return nothing.
// A query walks the faces, one face per cycle while no face touches the vertex, then runs
// up to 18 normalizing shifts, the 31-step square root and three 46-step divisions;
// one query is in work at a time and the input is ready again in the cycle after the
// result is loaded.
// Reset clears the controller, the register file and the result handshake; stores are undefined.
`timescale 1ns / 1ps
`default_nettype none

module area_weighted_vertex_normals (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    awvn_in_if.sink                              in_ch,
    awvn_out_if.source                           out_ch,
    input  wire logic                            cfg_we,
    input  wire logic [awvn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [awvn_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import awvn_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // controller
    awvn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    awvn_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_slot        (in_ch.slot),
        .in_pos_x       (in_ch.pos_x),
        .in_pos_y       (in_ch.pos_y),
        .in_pos_z       (in_ch.pos_z),
        .in_corner_a    (in_ch.corner_a),
        .in_corner_b    (in_ch.corner_b),
        .in_corner_c    (in_ch.corner_c),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .out_normal_x   (out_ch.normal_x),
        .out_normal_y   (out_ch.normal_y),
        .out_normal_z   (out_ch.normal_z),
        .out_faces_used (out_ch.faces_used),
        .out_status     (out_ch.status)
    );

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_ch.valid && !out_ch.ready))
        else $error("result loaded over a pending item");

    // out-of-range queries report nothing but the status
    a_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == ST_RANGE) |->
        (out_ch.faces_used == '0 && out_ch.normal_x == '0
         && out_ch.normal_y == '0 && out_ch.normal_z == '0))
        else $error("out-of-range item carries data");

    // a good normal has at least one nonzero component
    a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == ST_OK) |->
        (out_ch.normal_x != '0 || out_ch.normal_y != '0 || out_ch.normal_z != '0))
        else $error("ok item with zero normal");

    // loads and query starts are only taken while the input is ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_vtx || cmd.load_face || cmd.start) |-> in_ch.ready)
        else $error("store write or query start outside idle");

endmodule

`default_nettype wire

// ===== design/awvn_ctrl.sv =====
// awvn_ctrl: sequencer for loads and normal queries
// depends on awvn_pkg; drives the datapath through cmd_t and reads stat_t
`timescale 1ns / 1ps
`default_nettype none

module awvn_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [awvn_pkg::OP_W-1:0] in_opcode,
    output logic                          in_ready,
    input  awvn_pkg::stat_t               stat,
    output awvn_pkg::cmd_t                cmd
);
    import awvn_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE    = 19'b0000000000000000001,
        S_CHECK   = 19'b0000000000000000010,
        S_FMATCH  = 19'b0000000000000000100,
        S_VA      = 19'b0000000000000001000,
        S_VB      = 19'b0000000000000010000,
        S_VC      = 19'b0000000000000100000,
        S_MUL     = 19'b0000000000001000000,
        S_MDRAIN  = 19'b0000000000010000000,
        S_SUMCHK  = 19'b0000000000100000000,
        S_NORM    = 19'b0000000001000000000,
        S_SQ      = 19'b0000000010000000000,
        S_SQDRAIN = 19'b0000000100000000000,
        S_RINIT   = 19'b0000001000000000000,
        S_ROOT    = 19'b0000010000000000000,
        S_DINIT   = 19'b0000100000000000000,
        S_DIV     = 19'b0001000000000000000,
        S_DSTORE  = 19'b0010000000000000000,
        S_FINISH  = 19'b0100000000000000000,
        S_SPARE   = 19'b1000000000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STAT_W-1:0] fin_reg, fin_next;

    // state and final status registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        cmd.corner = CRN_A;
        cmd.status = fin_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_opcode)
                        OP_LOAD_VTX:  cmd.load_vtx = 1'b1;
                        OP_LOAD_FACE: cmd.load_face = 1'b1;
                        OP_QUERY:
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHECK:
            begin
                if (stat.out_of_range)
                begin
                    fin_next   = ST_RANGE;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_FMATCH;
                end
            end
            S_FMATCH:
            begin
                if (stat.walk_done)
                begin
                    state_next = S_SUMCHK;
                end
                else if (stat.face_hit)
                begin
                    cmd.hit_count = 1'b1;
                    cmd.corner    = CRN_A;
                    state_next    = S_VA;
                end
                else
                begin
                    cmd.face_next = 1'b1;
                end
            end
            S_VA:
            begin
                cmd.latch_a = 1'b1;
                cmd.corner  = CRN_B;
                state_next  = S_VB;
            end
            S_VB:
            begin
                cmd.latch_u = 1'b1;
                cmd.corner  = CRN_C;
                state_next  = S_VC;
            end
            S_VC:
            begin
                cmd.latch_w = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (stat.step_last)
                    state_next = S_MDRAIN;
            end
            S_MDRAIN:
            begin
                cmd.face_next = 1'b1;
                state_next    = S_FMATCH;
            end
            S_SUMCHK:
            begin
                cmd.sum_check = 1'b1;
                if (stat.sum_zero)
                begin
                    fin_next   = ST_ZERO;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (stat.norm_done)
                    state_next = S_SQ;
                else
                    cmd.norm_shift = 1'b1;
            end
            S_SQ:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_sq = 1'b1;
                if (stat.step_last)
                    state_next = S_SQDRAIN;
            end
            S_SQDRAIN:
            begin
                state_next = S_RINIT;
            end
            S_RINIT:
            begin
                cmd.root_init = 1'b1;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (stat.root_last)
                    state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_DSTORE;
            end
            S_DSTORE:
            begin
                cmd.div_store = 1'b1;
                if (stat.comp_last)
                begin
                    fin_next   = ST_OK;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DINIT;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/awvn_dp.sv =====
// awvn_dp: vertex and face stores, cross-product accumulation, square root,
// division and the result register; depends on awvn_pkg and is steered by awvn_ctrl
`timescale 1ns / 1ps
`default_nettype none

module awvn_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  awvn_pkg::cmd_t                          cmd,
    output awvn_pkg::stat_t                         stat,
    input  wire logic                               cfg_we,
    input  wire logic [awvn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [awvn_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [awvn_pkg::SLOT_W-1:0]        in_slot,
    input  wire logic signed [awvn_pkg::COORD_W-1:0] in_pos_x,
    input  wire logic signed [awvn_pkg::COORD_W-1:0] in_pos_y,
    input  wire logic signed [awvn_pkg::COORD_W-1:0] in_pos_z,
    input  wire logic [awvn_pkg::IDX_W-1:0]         in_corner_a,
    input  wire logic [awvn_pkg::IDX_W-1:0]         in_corner_b,
    input  wire logic [awvn_pkg::IDX_W-1:0]         in_corner_c,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic signed [awvn_pkg::NRM_W-1:0]       out_normal_x,
    output logic signed [awvn_pkg::NRM_W-1:0]       out_normal_y,
    output logic signed [awvn_pkg::NRM_W-1:0]       out_normal_z,
    output logic [awvn_pkg::CNT_W-1:0]              out_faces_used,
    output logic [awvn_pkg::STAT_W-1:0]             out_status
);
    import awvn_pkg::*;

    // stores
    logic [3*COORD_W-1:0] vtx_mem [VTX_DEPTH];
    logic [3*IDX_W-1:0]   face_mem [FACE_DEPTH];
    logic [3*COORD_W-1:0] vtx_q_reg;
    logic [3*IDX_W-1:0]   face_q_reg;
    logic [VTX_AW-1:0]    vaddr;

    // configuration
    logic [VCNT_W-1:0] vcount_reg;
    logic [CNT_W-1:0]  fcount_reg;
    logic [CNT_W-1:0]  walk_limit;

    // walk state
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  fidx_reg, fidx_next;
    logic [CNT_W-1:0]  used_reg;

    // corner positions and edge vectors
    logic signed [COORD_W-1:0] ax_reg, ay_reg, az_reg;
    logic signed [COORD_W-1:0] qx, qy, qz;
    logic signed [DIFF_W-1:0]  ux_reg, uy_reg, uz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [DIFF_W-1:0]  dx, dy, dz;

    // shared multiplier
    logic [STEP_W-1:0]        step_reg;
    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     acc_en_reg, acc_sq_reg;
    logic [STEP_W-1:0]        acc_sel_reg;
    logic signed [SUM_W-1:0]  prod_s;

    // sums and magnitudes
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [SUM_W-1:0]        mx_reg, my_reg, mz_reg;
    logic                    nx_reg, ny_reg, nz_reg;
    logic [SSQ_W-1:0]        ssq_reg;

    // square root
    logic [SSQ_W-1:0] rn_reg, rr_reg, rb_reg;
    logic [SSQ_W:0]   rsum;
    logic [ITER_W-1:0] iter_reg;
    logic [LEN_W-1:0] len_eff;
    logic [DIVS_W-1:0] div_d;

    // division
    logic [COMP_W-1:0] comp_reg;
    logic [DIVD_W-1:0] dvd_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [Q_W-1:0]    q_reg;
    logic [DIVS_W:0]   dtry;
    logic              dge;
    logic [MAG_W-1:0]  dmag;
    logic              dneg;
    logic [Q_W-1:0]    qsigned;

    // result
    logic signed [NRM_W-1:0] rx_reg, ry_reg, rz_reg;

    // vertex and face stores, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load_vtx && in_slot[SLOT_W-1] == 1'b0)
            vtx_mem[in_slot[VTX_AW-1:0]] <= {in_pos_x, in_pos_y, in_pos_z};
        vtx_q_reg <= vtx_mem[vaddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_face)
            face_mem[in_slot[FACE_AW-1:0]] <= {in_corner_a, in_corner_b, in_corner_c};
        face_q_reg <= face_mem[fidx_next[FACE_AW-1:0]];
    end

    always_comb
    begin
        case (cmd.corner)
            CRN_A:   vaddr = face_q_reg[3*IDX_W-1:2*IDX_W];
            CRN_B:   vaddr = face_q_reg[2*IDX_W-1:IDX_W];
            CRN_C:   vaddr = face_q_reg[IDX_W-1:0];
            default: vaddr = face_q_reg[3*IDX_W-1:2*IDX_W];
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            fcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_VERTEX_COUNT)
                vcount_reg <= cfg_wdata[VCNT_W-1:0];
            else if (cfg_index == CFG_FACE_COUNT)
                fcount_reg <= cfg_wdata;
        end
    end

    assign walk_limit = (fcount_reg > CNT_W'(FACE_DEPTH)) ? CNT_W'(FACE_DEPTH) : fcount_reg;

    // face walk index
    always_comb
    begin
        fidx_next = fidx_reg;
        if (cmd.start)
            fidx_next = '0;
        else if (cmd.face_next)
            fidx_next = fidx_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        fidx_reg <= fidx_next;
        if (cmd.start)
            slot_reg <= in_slot;
        if (cmd.start)
            used_reg <= '0;
        else if (cmd.hit_count && used_reg != CNT_W'(USED_MAX))
            used_reg <= used_reg + 1'b1;
    end

    // corner latch and edge vectors
    assign qx = vtx_q_reg[3*COORD_W-1:2*COORD_W];
    assign qy = vtx_q_reg[2*COORD_W-1:COORD_W];
    assign qz = vtx_q_reg[COORD_W-1:0];
    assign dx = DIFF_W'(ax_reg) - DIFF_W'(qx);
    assign dy = DIFF_W'(ay_reg) - DIFF_W'(qy);
    assign dz = DIFF_W'(az_reg) - DIFF_W'(qz);

    always_ff @(posedge clk)
    begin
        if (cmd.latch_a)
        begin
            ax_reg <= qx;
            ay_reg <= qy;
            az_reg <= qz;
        end
        if (cmd.latch_u)
        begin
            ux_reg <= dx;
            uy_reg <= dy;
            uz_reg <= dz;
        end
        if (cmd.latch_w)
        begin
            wx_reg <= dx;
            wy_reg <= dy;
            wz_reg <= dz;
        end
    end

    // multiplier operand select: six cross terms or three squares
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (cmd.mul_sq)
        begin
            case (step_reg)
                3'd0:    op_a = MUL_W'(mx_reg[MAG_W-1:0]);
                3'd1:    op_a = MUL_W'(my_reg[MAG_W-1:0]);
                default: op_a = MUL_W'(mz_reg[MAG_W-1:0]);
            endcase
            op_b = op_a;
        end
        else
        begin
            case (step_reg)
                3'd0:    begin op_a = MUL_W'(uy_reg); op_b = MUL_W'(wz_reg); end
                3'd1:    begin op_a = MUL_W'(uz_reg); op_b = MUL_W'(wy_reg); end
                3'd2:    begin op_a = MUL_W'(uz_reg); op_b = MUL_W'(wx_reg); end
                3'd3:    begin op_a = MUL_W'(ux_reg); op_b = MUL_W'(wz_reg); end
                3'd4:    begin op_a = MUL_W'(ux_reg); op_b = MUL_W'(wy_reg); end
                default: begin op_a = MUL_W'(uy_reg); op_b = MUL_W'(wx_reg); end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            acc_en_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= cmd.mul_en ? step_reg + 1'b1 : '0;
            acc_en_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= op_a * op_b;
        acc_sq_reg  <= cmd.mul_sq;
        acc_sel_reg <= step_reg;
    end

    assign prod_s = signed'(prod_reg[SUM_W-1:0]);

    // sum accumulation, magnitudes and normalizing shift
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sx_reg  <= '0;
            sy_reg  <= '0;
            sz_reg  <= '0;
            ssq_reg <= '0;
        end
        else if (acc_en_reg)
        begin
            if (acc_sq_reg)
            begin
                ssq_reg <= ssq_reg + prod_reg[SSQ_W-1:0];
            end
            else
            begin
                case (acc_sel_reg)
                    3'd0:    sx_reg <= sx_reg + prod_s;
                    3'd1:    sx_reg <= sx_reg - prod_s;
                    3'd2:    sy_reg <= sy_reg + prod_s;
                    3'd3:    sy_reg <= sy_reg - prod_s;
                    3'd4:    sz_reg <= sz_reg + prod_s;
                    default: sz_reg <= sz_reg - prod_s;
                endcase
            end
        end
        if (cmd.sum_check)
        begin
            mx_reg <= sx_reg[SUM_W-1] ? unsigned'(-sx_reg) : unsigned'(sx_reg);
            my_reg <= sy_reg[SUM_W-1] ? unsigned'(-sy_reg) : unsigned'(sy_reg);
            mz_reg <= sz_reg[SUM_W-1] ? unsigned'(-sz_reg) : unsigned'(sz_reg);
            nx_reg <= sx_reg[SUM_W-1];
            ny_reg <= sy_reg[SUM_W-1];
            nz_reg <= sz_reg[SUM_W-1];
        end
        else if (cmd.norm_shift)
        begin
            mx_reg <= mx_reg >> 1;
            my_reg <= my_reg >> 1;
            mz_reg <= mz_reg >> 1;
        end
    end

    // bit-serial integer square root, two bits of the radicand per step
    assign rsum = {1'b0, rr_reg} + {1'b0, rb_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.root_init)
        begin
            rn_reg <= ssq_reg;
            rr_reg <= '0;
            rb_reg <= SSQ_W'(1) << (2 * (ROOT_STEPS - 1));
        end
        else if (cmd.root_step)
        begin
            if ({1'b0, rn_reg} >= rsum)
            begin
                rn_reg <= rn_reg - rsum[SSQ_W-1:0];
                rr_reg <= (rr_reg >> 1) + rb_reg;
            end
            else
            begin
                rr_reg <= rr_reg >> 1;
            end
            rb_reg <= rb_reg >> 2;
        end
    end

    assign len_eff = (rr_reg[LEN_W-1:0] == '0) ? LEN_W'(1) : rr_reg[LEN_W-1:0];
    assign div_d   = {len_eff, 1'b0};

    // iteration counter shared by root and divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_reg <= '0;
        else if (cmd.root_init || cmd.div_init)
            iter_reg <= '0;
        else if (cmd.root_step || cmd.div_step)
            iter_reg <= iter_reg + 1'b1;
    end

    // component select for the divider
    always_comb
    begin
        case (comp_reg)
            2'd0:    begin dmag = mx_reg[MAG_W-1:0]; dneg = nx_reg; end
            2'd1:    begin dmag = my_reg[MAG_W-1:0]; dneg = ny_reg; end
            default: begin dmag = mz_reg[MAG_W-1:0]; dneg = nz_reg; end
        endcase
    end

    // restoring divider, one quotient bit per step
    assign dtry = {rem_reg, dvd_reg[DIVD_W-1]};
    assign dge  = (dtry >= {1'b0, div_d});
    assign qsigned = dneg ? (~q_reg + 1'b1) : q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            comp_reg <= '0;
        else if (cmd.div_store)
            comp_reg <= comp_reg + 1'b1;
        if (cmd.div_init)
        begin
            dvd_reg <= DIVD_W'({dmag, QSH'(0)}) + DIVD_W'(len_eff);
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= dge ? DIVS_W'(dtry - {1'b0, div_d}) : dtry[DIVS_W-1:0];
            q_reg   <= {q_reg[Q_W-2:0], dge};
        end
        if (cmd.start)
        begin
            rx_reg <= '0;
            ry_reg <= '0;
            rz_reg <= '0;
        end
        else if (cmd.div_store)
        begin
            case (comp_reg)
                2'd0:    rx_reg <= signed'(qsigned);
                2'd1:    ry_reg <= signed'(qsigned);
                default: rz_reg <= signed'(qsigned);
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.out_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_normal_x   <= rx_reg;
            out_normal_y   <= ry_reg;
            out_normal_z   <= rz_reg;
            out_faces_used <= used_reg;
            out_status     <= cmd.status;
        end
    end

    // status to controller
    always_comb
    begin
        stat.out_of_range = ({1'b0, slot_reg} >= {1'b0, vcount_reg})
                            || (slot_reg >= SLOT_W'(VTX_DEPTH));
        stat.walk_done    = (fidx_reg == walk_limit);
        stat.face_hit     = (face_q_reg[3*IDX_W-1:2*IDX_W] == slot_reg[IDX_W-1:0]
                             || face_q_reg[2*IDX_W-1:IDX_W] == slot_reg[IDX_W-1:0]
                             || face_q_reg[IDX_W-1:0] == slot_reg[IDX_W-1:0])
                            && slot_reg[SLOT_W-1] == 1'b0;
        stat.sum_zero     = (sx_reg == '0) && (sy_reg == '0) && (sz_reg == '0);
        stat.norm_done    = (mx_reg[SUM_W-1:MAG_W] == '0) && (my_reg[SUM_W-1:MAG_W] == '0)
                            && (mz_reg[SUM_W-1:MAG_W] == '0);
        stat.step_last    = cmd.mul_sq ? (step_reg == STEP_W'(SQ_STEPS - 1))
                                       : (step_reg == STEP_W'(CROSS_STEPS - 1));
        stat.root_last    = (iter_reg == ITER_W'(ROOT_STEPS - 1));
        stat.div_last     = (iter_reg == ITER_W'(DIV_STEPS - 1));
        stat.comp_last    = (comp_reg == COMP_W'(2));
        stat.out_full     = out_valid && !out_ready;
    end

endmodule

`default_nettype wire
